@@ hdl/sha512_pkg.sv @@
// Package with the round constants, IVs and shared types of the SHA-512 hash core.
`default_nettype none
package sha512_pkg;

    localparam int MAX_ROUNDS_DEF = 160;
    localparam int KTAB_DEPTH     = 160;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [2:0]  word_index;
        logic        digest_last;
    } t_out_item;

    localparam logic [0:0] CFG_ROUND_COUNT  = 1'd0;
    localparam logic [0:0] CFG_DIGEST_BYTES = 1'd1;

    localparam logic [63:0] KTAB [KTAB_DEPTH] = '{
     64'h428A2F98D728AE22,64'h7137449123EF65CD,64'hB5C0FBCFEC4D3B2F,64'hE9B5DBA58189DBBC,
     64'h3956C25BF348B538,64'h59F111F1B605D019,64'h923F82A4AF194F9B,64'hAB1C5ED5DA6D8118,
     64'hD807AA98A3030242,64'h12835B0145706FBE,64'h243185BE4EE4B28C,64'h550C7DC3D5FFB4E2,
     64'h72BE5D74F27B896F,64'h80DEB1FE3B1696B1,64'h9BDC06A725C71235,64'hC19BF174CF692694,
     64'hE49B69C19EF14AD2,64'hEFBE4786384F25E3,64'h0FC19DC68B8CD5B5,64'h240CA1CC77AC9C65,
     64'h2DE92C6F592B0275,64'h4A7484AA6EA6E483,64'h5CB0A9DCBD41FBD4,64'h76F988DA831153B5,
     64'h983E5152EE66DFAB,64'hA831C66D2DB43210,64'hB00327C898FB213F,64'hBF597FC7BEEF0EE4,
     64'hC6E00BF33DA88FC2,64'hD5A79147930AA725,64'h06CA6351E003826F,64'h142929670A0E6E70,
     64'h27B70A8546D22FFC,64'h2E1B21385C26C926,64'h4D2C6DFC5AC42AED,64'h53380D139D95B3DF,
     64'h650A73548BAF63DE,64'h766A0ABB3C77B2A8,64'h81C2C92E47EDAEE6,64'h92722C851482353B,
     64'hA2BFE8A14CF10364,64'hA81A664BBC423001,64'hC24B8B70D0F89791,64'hC76C51A30654BE30,
     64'hD192E819D6EF5218,64'hD69906245565A910,64'hF40E35855771202A,64'h106AA07032BBD1B8,
     64'h19A4C116B8D2D0C8,64'h1E376C085141AB53,64'h2748774CDF8EEB99,64'h34B0BCB5E19B48A8,
     64'h391C0CB3C5C95A63,64'h4ED8AA4AE3418ACB,64'h5B9CCA4F7763E373,64'h682E6FF3D6B2B8A3,
     64'h748F82EE5DEFB2FC,64'h78A5636F43172F60,64'h84C87814A1F0AB72,64'h8CC702081A6439EC,
     64'h90BEFFFA23631E28,64'hA4506CEBDE82BDE9,64'hBEF9A3F7B2C67915,64'hC67178F2E372532B,
     64'hCA273ECEEA26619C,64'hD186B8C721C0C207,64'hEADA7DD6CDE0EB1E,64'hF57D4F7FEE6ED178,
     64'h06F067AA72176FBA,64'h0A637DC5A2C898A6,64'h113F9804BEF90DAE,64'h1B710B35131C471B,
     64'h28DB77F523047D84,64'h32CAAB7B40C72493,64'h3C9EBE0A15C9BEBC,64'h431D67C49C100D4C,
     64'h4CC5D4BECB3E42B6,64'h597F299CFC657E2A,64'h5FCB6FAB3AD6FAEC,64'h6C44198C4A475817,
     64'h7BA0EA2D98160007,64'h7EABF2D0C21F964A,64'h8DBE8D038B409545,64'h90BB1721582E8285,
     64'h99A2AD45936D4E61,64'h9F86E289FE03E739,64'hA84C4472FAA9A82F,64'hB3DF34FCE89E0532,
     64'hB99BB8D7B173534F,64'hBC76CBAB1AEA1F9C,64'hC226A69A780F3CC3,64'hD304F19AA233957D,
     64'hDE1BE20A212129DD,64'hE39BB43755141950,64'hEE84927CEA48DDD2,64'hF3EDD2773C523B67,
     64'hFBFDFE53A8D32F2A,64'h0BEE2C7AB77E9E25,64'h0E90181CF1B09E56,64'h25F57204C725BED8,
     64'h2DA45582CD598B32,64'h3A52C34C203BFCF3,64'h41DC0172CD1991C1,64'h495796FCB33CC1C0,
     64'h4BD31FC693F9F16E,64'h533CDE2115F5A9A0,64'h5F7ABFE36E99C1D3,64'h66C206B310A57E6F,
     64'h6DFCC6BC39603F61,64'h7062F20F86FD1052,64'h778D51277ADEC865,64'h7EABA3CC25DA7048,
     64'h8363ECCC37A5BE05,64'h85BE1C253BEBA54E,64'h93C04028F348BBC5,64'h9F4A205FD05B2148,
     64'hA19535651CA6D2DE,64'hA627BB0FBF027BC7,64'hACFA80891DA2F06B,64'hB3C29B23031A7F9D,
     64'hB602F6FAC7D3D74D,64'hC36CEE0A10C7BA49,64'hC7DC81EEA9EBAD4F,64'hCE7B8471B0F809DF,
     64'hD740288C84DF269C,64'hE21DBA7AC2290607,64'hEABBFF66BE175964,64'hF56A9E60F62CEA92,
     64'hFDE41D729D126EAB,64'h0434D0970E42E781,64'h0A7CB752A3F1CD86,64'h0EA7D22D6BCD7382,
     64'h16F2987F9495A5EE,64'h1D20CDCD45B8DE1E,64'h213AF85A39B0C320,64'h2964505C52A2F35B,
     64'h2D738E114181E082,64'h3B8CEA0E71C58AAF,64'h4584E6AE9F54016E,64'h515F4356903DCCC2,
     64'h5356112DDFD5A8E9,64'h5D1BC3EDBE2C897A,64'h5F0DA9F8ED53548B,64'h62EF0BE4D5492E78,
     64'h64DE896EACE0BE7F,64'h6E801BA3078AE05F,64'h7BDB3595CDADF50A,64'h7FA5377856834C98,
     64'h818916BAD3D008A8,64'h854E959F834021A7,64'h926A82C27137E2C6,64'h9622C7BA7D179197,
     64'h97FDD5929D59CE21,64'h9BB1CB7470162D7E,64'hAE0B55609FFEA9D5,64'hB1AE88AB4ECA7239,
     64'hB8ECC9F6468460A1,64'hC1EB8968A81A3124,64'hC911DD821BB6B418,64'hCCA11FE32D0C58D0
    };

    localparam logic [63:0] IV512 [8] = '{
     64'h6A09E667F3BCC908,64'hBB67AE8584CAA73B,64'h3C6EF372FE94F82B,64'hA54FF53A5F1D36F1,
     64'h510E527FADE682D1,64'h9B05688C2B3E6C1F,64'h1F83D9ABFB41BD6B,64'h5BE0CD19137E2179
    };
    localparam logic [63:0] IV384 [8] = '{
     64'hCBBB9D5DC1059ED8,64'h629A292A367CD507,64'h9159015A3070DD17,64'h152FECD8F70E5939,
     64'h67332667FFC00B31,64'h8EB44A8768581511,64'hDB0C2E0D64F98FA7,64'h47B5481DBEFA4FA4
    };

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage
`default_nettype wire

@@ hdl/sha512_hash_core_unit.sv @@
// Top level of the SHA-512 family hash core with a configurable round count.
`default_nettype none
// The core takes the message as big-endian 64-bit words, one transfer at a
// time, and hashes it with one shared round unit that does one compression
// round per clock. An aligned full word goes through the transfer, the store
// into the block and the return to idle. Every sixteenth word fills a
// 128-byte block, which then runs its rounds (80 by default) and the
// chaining update. A word that is not full enters one byte per cycle, held
// while a filled block is compressed. On the word marked last the core pads
// one byte per cycle up to the next word boundary and then a word per cycle,
// runs one or two more compressions, and then offers ceil(min(digest_bytes,
// 64)/8) digest words, one transfer each; no input is taken until the last
// digest word has left. A configuration write abandons any message in
// progress and reloads the IV chosen by the digest size.
module sha512_hash_core_unit
    import sha512_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_BYTES, S_PAD, S_ROUND, S_UPDATE, S_OUT
    } t_state;

    t_state       r_state, n_state;
    logic [7:0]   r_round_count;
    logic [6:0]   r_digest_bytes;
    logic [63:0]  r_chain [8];
    logic [63:0]  r_w [16];
    logic [63:0]  r_v [8];
    logic [6:0]   r_pos;
    logic [63:0]  r_len_lo, r_len_hi;
    logic [7:0]   r_rnd;
    logic [63:0]  r_word;
    logic [3:0]   r_cnt;
    logic [3:0]   r_bidx;
    logic         r_last;
    logic         r_final;     // compression in flight is the last of the message
    logic         r_pad_done;  // 0x80 already placed
    logic [3:0]   r_oidx;
    logic [3:0]   r_nw;

    logic [7:0]   eff_rounds;
    logic [6:0]   db_clamped;
    logic [3:0]   n_words;
    logic [63:0]  wi, t1, t2, snew;
    logic [3:0]   ri;
    logic [7:0]   byte_val;

    // Effective round count: zero means 80, at least 16, multiple of 8, capped.
    always_comb begin
        logic [8:0] n;
        n = {1'b0, r_round_count};
        if (n == 9'd0) n = 9'd80;
        if (n < 9'd16) n = 9'd16;
        n = (n + 9'd7) & ~9'd7;
        if (n > 9'(MAX_ROUNDS)) n = 9'(MAX_ROUNDS);
        eff_rounds = n[7:0];
    end

    assign db_clamped = (r_digest_bytes > 7'd64) ? 7'd64 : r_digest_bytes;
    assign n_words    = 4'((8'(db_clamped) + 8'd7) >> 3);

    // Shared round unit: schedule expansion and one compression round.
    assign ri = r_rnd[3:0];
    always_comb begin
        logic [63:0] x, y;
        x    = r_w[ri + 4'd1];
        y    = r_w[ri + 4'd14];
        snew = r_w[ri] + (rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7)) + r_w[ri + 4'd9]
             + (rotr(y, 19) ^ rotr(y, 61) ^ (y >> 6));
        wi   = (r_rnd >= 8'd16) ? snew : r_w[ri];
        t1   = r_v[7] + (rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41))
             + (r_v[6] ^ (r_v[4] & (r_v[5] ^ r_v[6]))) + KTAB[r_rnd] + wi;
        t2   = (rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39))
             + ((r_v[0] & r_v[1]) | (r_v[2] & (r_v[0] | r_v[1])));
    end

    assign byte_val = r_word[63 - 8*r_bidx[2:0] -: 8];
    assign o_ready  = (r_state == S_IDLE) && !i_cfg_we;
    assign o_valid  = (r_state == S_OUT);
    assign o_data.digest_word = r_chain[r_oidx[2:0]];
    assign o_data.word_index  = r_oidx[2:0];
    assign o_data.digest_last = (r_oidx + 4'd1 == r_nw);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid && o_ready) n_state = S_BYTES;
            S_BYTES:  n_state = S_BYTES;
            S_PAD:    n_state = S_PAD;
            S_ROUND:  if (r_rnd + 8'd1 == eff_rounds) n_state = S_UPDATE;
            S_UPDATE: n_state = S_UPDATE;
            S_OUT:    n_state = S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_round_count  <= 8'd80;
            r_digest_bytes <= 7'd64;
            r_chain        <= IV512;
            r_pos          <= '0;
            r_len_lo       <= '0;
            r_len_hi       <= '0;
            r_rnd          <= '0;
            r_oidx         <= '0;
        end else if (i_cfg_we) begin
            // Configuration is to be written only while idle (not enforced); restart the message.
            unique case (i_cfg_index)
                CFG_ROUND_COUNT:  r_round_count <= i_cfg_data;
                CFG_DIGEST_BYTES: begin
                    r_digest_bytes <= i_cfg_data[6:0];
                end
                default: ;
            endcase
            if (i_cfg_index == CFG_DIGEST_BYTES)
                r_chain <= (i_cfg_data[6:0] > 7'd48) ? IV512 : IV384;
            else
                r_chain <= (r_digest_bytes > 7'd48) ? IV512 : IV384;
            r_pos    <= '0;
            r_len_lo <= '0;
            r_len_hi <= '0;
            r_state  <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_word     <= i_data.data_word;
                        r_cnt      <= (i_data.byte_count > 4'd8) ? 4'd8 : i_data.byte_count;
                        r_last     <= i_data.last;
                        r_bidx     <= '0;
                        r_pad_done <= 1'b0;
                        r_state    <= S_BYTES;
                    end
                end
                S_BYTES: begin
                    if (r_bidx == r_cnt) begin
                        if (r_last) begin
                            {r_len_hi, r_len_lo} <= {r_len_hi, r_len_lo}
                                                  + 128'({r_pos, 3'b000});
                            r_pad_done <= 1'b0;
                            r_state    <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (r_bidx == '0 && r_cnt == 4'd8 && r_pos[2:0] == 3'd0) begin
                        // Aligned full word goes in at once.
                        r_w[r_pos[6:3]] <= r_word;
                        r_bidx <= 4'd8;
                        if (r_pos == 7'd120) begin
                            {r_len_hi, r_len_lo} <= {r_len_hi, r_len_lo} + 128'd1024;
                            r_pos   <= '0;
                            r_v     <= r_chain;
                            r_rnd   <= '0;
                            r_final <= 1'b0;
                            r_state <= S_ROUND;
                        end else begin
                            r_pos <= r_pos + 7'd8;
                        end
                    end else begin
                        r_w[r_pos[6:3]][63 - 8*r_pos[2:0] -: 8] <= byte_val;
                        r_bidx <= r_bidx + 4'd1;
                        if (r_pos == 7'd127) begin
                            {r_len_hi, r_len_lo} <= {r_len_hi, r_len_lo} + 128'd1024;
                            r_pos   <= '0;
                            r_v     <= r_chain;
                            r_rnd   <= '0;
                            r_final <= 1'b0;
                            r_state <= S_ROUND;
                        end else begin
                            r_pos <= r_pos + 7'd1;
                        end
                    end
                end
                S_PAD: begin
                    if (!r_pad_done || r_pos[2:0] != 3'd0) begin
                        r_w[r_pos[6:3]][63 - 8*r_pos[2:0] -: 8] <=
                            r_pad_done ? 8'h00 : 8'h80;
                        r_pad_done <= 1'b1;
                        r_pos <= r_pos + 7'd1;
                        if (r_pos == 7'd127) begin
                            r_v     <= r_chain;
                            r_rnd   <= '0;
                            r_final <= 1'b0;
                            r_state <= S_ROUND;
                        end
                    end else if (r_pos == 7'd112) begin
                        r_w[14]  <= r_len_hi;
                        r_w[15]  <= r_len_lo;
                        r_v      <= r_chain;
                        r_rnd    <= '0;
                        r_final  <= 1'b1;
                        r_state  <= S_ROUND;
                    end else begin
                        // Word-aligned zero fill, a word per cycle until the block is full.
                        r_w[r_pos[6:3]] <= '0;
                        if (r_pos == 7'd120) begin
                            r_pos   <= '0;
                            r_v     <= r_chain;
                            r_rnd   <= '0;
                            r_final <= 1'b0;
                            r_state <= S_ROUND;
                        end else begin
                            r_pos <= r_pos + 7'd8;
                        end
                    end
                end
                S_ROUND: begin
                    if (r_rnd >= 8'd16) r_w[ri] <= snew;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_rnd  <= r_rnd + 8'd1;
                    r_state <= n_state;
                end
                S_UPDATE: begin
                    // An empty digest restarts at once with a fresh IV.
                    if (r_final && n_words == 4'd0)
                        r_chain <= (r_digest_bytes > 7'd48) ? IV512 : IV384;
                    else
                        for (int k = 0; k < 8; k++) r_chain[k] <= r_chain[k] + r_v[k];
                    if (r_final) begin
                        r_pos    <= '0;
                        r_len_lo <= '0;
                        r_len_hi <= '0;
                        r_nw     <= n_words;
                        r_oidx   <= '0;
                        r_state  <= (n_words == 4'd0) ? S_IDLE : S_OUT;
                    end else if (r_pad_done) begin
                        r_state <= S_PAD;
                    end else begin
                        r_state <= S_BYTES;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oidx <= r_oidx + 4'd1;
                        if (r_oidx + 4'd1 == r_nw) begin
                            r_chain <= (r_digest_bytes > 7'd48) ? IV512 : IV384;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Rounds never run past the effective count.
    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_rnd < eff_rounds))
        else $error("round counter past effective round count");
    // Digest words stay within the number requested.
    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_oidx < r_nw))
        else $error("digest index past word count");
    // No input is taken while a digest is being offered.
    a_no_in_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready during digest output");

endmodule
`default_nettype wire
